FILE: design/sha256sh_pkg.sv
// sha256sh_pkg: shared types and constants for the SHA-256 stream hasher.
// Holds the word and hash types, the round constants and the initial hash.
// No dependencies; used by sha256sh_round and sha256_stream_hasher_core.
package sha256sh_pkg;

    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int BLK_W  = 512;   // one 64-byte message block

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // Eight working or chaining words, index 0 is H0 / a
    typedef word_t [0:7] hash_t;

    // Message schedule taps relative to the current round word w[t]
    typedef struct packed {
        word_t w0;    // w[t]
        word_t w1;    // w[t+1]
        word_t w9;    // w[t+9]
        word_t w14;   // w[t+14]
    } sched_taps_t;

    localparam byte_t      PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam hash_t INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: design/sha256sh_round.sv
// sha256sh_round: one SHA-256 compression round plus one schedule word.
// Combinational; the top level registers its results every round cycle.
// Depends on sha256sh_pkg.
module sha256sh_round (
    input  sha256sh_pkg::hash_t       v,
    input  sha256sh_pkg::word_t       k,
    input  sha256sh_pkg::sched_taps_t taps,
    output sha256sh_pkg::hash_t       v_new,
    output sha256sh_pkg::word_t       w_new
);

    function automatic sha256sh_pkg::word_t rotr(input sha256sh_pkg::word_t x, input int n);
        return (x >> n) | (x << (sha256sh_pkg::WORD_W - n));
    endfunction

    sha256sh_pkg::word_t big0;
    sha256sh_pkg::word_t big1;
    sha256sh_pkg::word_t ch;
    sha256sh_pkg::word_t maj;
    sha256sh_pkg::word_t t1;
    sha256sh_pkg::word_t s0;
    sha256sh_pkg::word_t s1;

    // Round function
    assign big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    assign t1   = v[7] + big1 + ch + k + taps.w0;
    assign big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);

    always_comb
    begin
        v_new[0] = t1 + big0 + maj;
        v_new[1] = v[0];
        v_new[2] = v[1];
        v_new[3] = v[2];
        v_new[4] = v[3] + t1;
        v_new[5] = v[4];
        v_new[6] = v[5];
        v_new[7] = v[6];
    end

    // Schedule: w[t+16] from the sliding window
    assign s0    = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
    assign s1    = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
    assign w_new = s1 + taps.w9 + s0 + taps.w0;

endmodule

FILE: design/sha256_stream_hasher_core.sv
// sha256_stream_hasher_core: byte-stream SHA-256 with padding and digest output.
// Top level; instantiates sha256sh_round, uses sha256sh_pkg.
//
//   channel | handshake         | beat fields
//   --------+-------------------+-------------------------------------------
//   in      | in_valid/in_ready | data_byte, byte_present, end_of_message
//   out     | out_valid/out_ready| digest_word, word_index, last_word
//
// Message bytes go into the block shifter; the 64th byte of a block starts a
// compression (the rounds of the one shared round unit, then a fold into the chain).
// At end of message the padding bytes go through the same byte shifter, one a
// cycle, with one or two more compressions, then 8 output beats.
// in_ready is high only while idle; out stalls hold the digest words as they are.
// Reset (rst_n low) loads the initial hash and clears the byte count.
module sha256_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_COMP, ST_FOLD, ST_OUT} state_t;

    state_t               state_reg, state_next;
    logic [5:0]           fill_reg, fill_next;
    logic [5:0]           round_reg, round_next;
    logic [2:0]           idx_reg, idx_next;
    logic [63:0]          byte_total_reg, byte_total_next;
    sha256sh_pkg::hash_t  h_reg, h_next;
    logic                 fin_reg, fin_next;
    logic                 mark_reg, mark_next;
    logic                 len_ok_reg, len_ok_next;

    logic [sha256sh_pkg::BLK_W-1:0] blk_reg;
    logic [63:0]                    len_reg;
    sha256sh_pkg::hash_t            v_reg;

    logic                     in_fire;
    logic                     out_fire;
    logic                     byte_load;
    logic                     len_slot;
    sha256sh_pkg::byte_t      pad_byte;
    sha256sh_pkg::byte_t      shift_byte;
    sha256sh_pkg::sched_taps_t taps;
    sha256sh_pkg::hash_t      v_new;
    sha256sh_pkg::word_t      w_new;

    // Handshakes
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == sha256sh_pkg::LAST_IDX);

    // Padding byte: mark, then zeros, then the length in the last eight slots
    assign len_slot   = mark_reg && len_ok_reg && (fill_reg >= sha256sh_pkg::LEN_POS);
    assign pad_byte   = !mark_reg ? sha256sh_pkg::PAD_MARK :
                        (len_slot ? len_reg[63:56] : 8'h00);
    assign shift_byte = (state_reg == ST_IDLE) ? data_byte : pad_byte;
    assign byte_load  = (in_fire && byte_present) || (state_reg == ST_PAD);

    // Schedule window taps: word j sits at the top of the block shifter
    assign taps.w0  = blk_reg[511:480];
    assign taps.w1  = blk_reg[479:448];
    assign taps.w9  = blk_reg[223:192];
    assign taps.w14 = blk_reg[63:32];

    sha256sh_round u_round (
        .v     (v_reg),
        .k     (sha256sh_pkg::ROUND_K[round_reg]),
        .taps  (taps),
        .v_new (v_new),
        .w_new (w_new)
    );

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        byte_total_next = byte_total_reg;
        h_next          = h_reg;
        fin_next        = fin_reg;
        mark_next       = mark_reg;
        len_ok_next     = len_ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_present)
                    begin
                        byte_total_next = byte_total_reg + 64'd1;
                        fill_next       = fill_reg + 6'd1;
                    end
                    if (end_of_message)
                    begin
                        fin_next    = 1'b1;
                        mark_next   = 1'b0;
                        len_ok_next = 1'b0;
                    end
                    if (byte_present && (fill_reg == sha256sh_pkg::LAST_POS))
                    begin
                        state_next = ST_COMP;
                        round_next = 6'd0;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                fill_next = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    mark_next   = 1'b1;
                    len_ok_next = (fill_reg < sha256sh_pkg::LEN_POS);
                end
                if (fill_reg == sha256sh_pkg::LAST_POS)
                begin
                    state_next = ST_COMP;
                    round_next = 6'd0;
                end
            end
            ST_COMP:
            begin
                round_next = round_reg + 6'd1;
                if (round_reg == sha256sh_pkg::LAST_RND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i] = h_reg[i] + v_reg[i];
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (len_ok_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = 3'd0;
                end
                else
                begin
                    // last data block or overflow block done; the next one carries the length
                    state_next = ST_PAD;
                    if (mark_reg)
                        len_ok_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256sh_pkg::LAST_IDX)
                    begin
                        h_next          = sha256sh_pkg::INIT_HASH;
                        byte_total_next = 64'd0;
                        fin_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 6'd0;
            round_reg      <= 6'd0;
            idx_reg        <= 3'd0;
            byte_total_reg <= 64'd0;
            h_reg          <= sha256sh_pkg::INIT_HASH;
            fin_reg        <= 1'b0;
            mark_reg       <= 1'b0;
            len_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            byte_total_reg <= byte_total_next;
            h_reg          <= h_next;
            fin_reg        <= fin_next;
            mark_reg       <= mark_next;
            len_ok_reg     <= len_ok_next;
        end
    end

    // Datapath: block shifter / schedule window, bit length, working words
    always_ff @(posedge clk)
    begin
        if (byte_load)
            blk_reg <= {blk_reg[sha256sh_pkg::BLK_W-9:0], shift_byte};
        else if (state_reg == ST_COMP)
            blk_reg <= {blk_reg[sha256sh_pkg::BLK_W-33:0], w_new};

        if (in_fire && end_of_message)
            len_reg <= (byte_total_reg + {63'd0, byte_present}) << 3;
        else if ((state_reg == ST_PAD) && len_slot)
            len_reg <= {len_reg[55:0], 8'h00};

        if ((state_next == ST_COMP) && (state_reg != ST_COMP))
            v_reg <= h_reg;
        else if (state_reg == ST_COMP)
            v_reg <= v_new;
    end

endmodule

FILE: design/sha256sh_checker.sv
// sha256sh_checker: port-level assertions for sha256_stream_hasher_core.
// Bound to the top level below; sees only its ports.
module sha256sh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // Input is never taken while a digest is being delivered
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("in_ready while digest pending");

    // Stalled digest beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
        else $error("digest beat changed under stall");

    // Digest words come out in order without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && (word_index == 3'($past(word_index) + 3'd1)))
        else $error("digest word order broken");

    // After the last digest beat the block takes input again
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> in_ready && !out_valid)
        else $error("not idle after last digest word");

    // End of message always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_message |=> !in_ready)
        else $error("end of message did not start padding");

endmodule

bind sha256_stream_hasher_core sha256sh_checker u_sha256sh_checker (.*);

FILE: test/sha256_stream_hasher_core_test.sv
// sha256_stream_hasher_core_test: self-checking bench for the byte-stream SHA-256 hasher.
// Drives byte beats and checks every digest word against a bit-exact SHA-256 model.
// Depends on sha256sh_pkg and sha256_stream_hasher_core from the design folder.
`timescale 1ns / 1ps

module sha256_stream_hasher_core_test;

    typedef sha256sh_pkg::word_t word_t;
    typedef sha256sh_pkg::byte_t byte_t;

    // One input beat plus the idle cycles the driver inserts after it
    typedef struct {
        byte_t       data;
        logic        present;
        logic        eom;
        int unsigned idle_after;
    } byte_beat_t;

    // One expected digest word
    typedef struct {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_word_t;

    localparam int    TARGET_BEATS = 430;
    localparam int    DRAIN_CYCLES = 300;
    localparam byte_t PAD_BYTE     = 8'h80;
    localparam int    LEN_AT       = 56;

    // Independent copies of the FIPS 180-4 constants
    localparam word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Model state: chaining value, block buffer, message byte count
    word_t        chain [8];
    byte_t        blk [64];
    logic [63:0]  msg_len;

    byte_beat_t   pending_beats [$];
    byte_beat_t   held_beat;
    digest_word_t digest_words_due [$];
    digest_word_t due_word;
    int unsigned  idle_left = 0;
    int unsigned  stall_left = 0;
    int unsigned  pause_draw;
    logic         calm_out = 1'b0;
    int           mismatches = 0;

    sha256_stream_hasher_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic word_t rotr32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64-round compression of blk into chain
    task automatic sha_fold();
        word_t sched [64];
        word_t v [8];
        word_t s0, s1, t1, t2;
        int    t;
        for (t = 0; t < 16; t++)
            sched[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (t = 16; t < 64; t++)
        begin
            s0 = rotr32(sched[t-15], 7) ^ rotr32(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rotr32(sched[t-2], 17) ^ rotr32(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
        end
        for (t = 0; t < 8; t++)
            v[t] = chain[t];
        for (t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + sched[t];
            t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++)
            chain[t] = chain[t] + v[t];
    endtask

    // Fold one accepted beat into the model; queue the digest on end of message
    task automatic hash_absorb(input byte_beat_t b);
        int          pos;
        int          k;
        logic [63:0] bit_len;
        if (b.present)
        begin
            pos = int'(msg_len[5:0]);
            blk[pos] = b.data;
            msg_len = msg_len + 64'd1;
            if (pos == 63)
                sha_fold();
        end
        if (!b.eom)
            return;
        // padding: marker, zeros, big-endian bit length
        pos = int'(msg_len[5:0]);
        blk[pos] = PAD_BYTE;
        pos = pos + 1;
        if (pos > LEN_AT)
        begin
            while (pos < 64)
            begin
                blk[pos] = 8'h00;
                pos = pos + 1;
            end
            sha_fold();
            pos = 0;
        end
        while (pos < LEN_AT)
        begin
            blk[pos] = 8'h00;
            pos = pos + 1;
        end
        bit_len = msg_len << 3;
        for (k = 0; k < 8; k++)
            blk[LEN_AT + k] = bit_len[63 - 8*k -: 8];
        sha_fold();
        for (k = 0; k < 8; k++)
            digest_words_due.push_back('{chain[k], 3'(k), k == 7});
        for (k = 0; k < 8; k++)
            chain[k] = IV_WORDS[k];
        msg_len = '0;
    endtask

    task automatic queue_beat(input byte_t d, input logic p, input logic e,
                              input int unsigned idle);
        byte_beat_t b;
        b.data       = d;
        b.present    = p;
        b.eom        = e;
        b.idle_after = idle;
        pending_beats.push_back(b);
    endtask

    // Driver: present the next pending beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            data_byte      <= 8'h00;
            byte_present   <= 1'b0;
            end_of_message <= 1'b0;
            idle_left      <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                hash_absorb(held_beat);
            if (idle_left != 0)
            begin
                in_valid  <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_beats.size() != 0)
            begin
                held_beat      = pending_beats.pop_front();
                data_byte      <= held_beat.data;
                byte_present   <= held_beat.present;
                end_of_message <= held_beat.eom;
                in_valid       <= 1'b1;
                idle_left      <= held_beat.idle_after;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each digest beat, then draw a stall before the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            calm_out   <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            if (digest_words_due.size() == 0)
                report_mismatch($sformatf("unexpected digest beat word=%h idx=%0d last=%b",
                                          digest_word, word_index, last_word));
            else
            begin
                due_word = digest_words_due.pop_front();
                if (digest_word !== due_word.word)
                    report_mismatch($sformatf("digest_word idx %0d: got %h want %h",
                                              due_word.idx, digest_word, due_word.word));
                if (word_index !== due_word.idx)
                    report_mismatch($sformatf("word_index: got %0d want %0d",
                                              word_index, due_word.idx));
                if (last_word !== due_word.last)
                    report_mismatch($sformatf("last_word idx %0d: got %b want %b",
                                              due_word.idx, last_word, due_word.last));
            end
            if (last_word)
                calm_out <= ($urandom_range(0, 3) == 0);
            pause_draw = calm_out ? 0 : $urandom_range(0, 10);
            stall_left <= pause_draw;
            out_ready  <= (pause_draw == 0);
        end
        else if (stall_left > 1)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= 0;
            out_ready  <= 1'b1;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int          counted;
        int          msg_bytes;
        int          i;
        int unsigned fill_mode;
        logic        calm_in;
        byte_t       b;

        for (i = 0; i < 8; i++)
            chain[i] = IV_WORDS[i];
        for (i = 0; i < 64; i++)
            blk[i] = 8'h00;
        msg_len = '0;

        // Directed: idle beat, empty messages, ignored byte, short messages
        queue_beat(8'h5a, 1'b0, 1'b0, $urandom_range(0, 10));
        queue_beat(8'h00, 1'b0, 1'b1, $urandom_range(0, 10));
        queue_beat(8'hff, 1'b0, 1'b1, 0);
        queue_beat(8'h61, 1'b1, 1'b0, 0);
        queue_beat(8'h62, 1'b1, 1'b0, 0);
        queue_beat(8'h63, 1'b1, 1'b1, $urandom_range(0, 10));
        queue_beat(8'h00, 1'b1, 1'b0, $urandom_range(0, 10));
        queue_beat(8'hab, 1'b0, 1'b0, 0);
        queue_beat(8'hff, 1'b1, 1'b1, 0);
        queue_beat(8'hff, 1'b1, 1'b0, 0);
        queue_beat(8'h00, 1'b0, 1'b1, 0);
        queue_beat(8'h80, 1'b1, 1'b1, $urandom_range(0, 10));
        queue_beat(8'h00, 1'b1, 1'b1, 0);
        queue_beat(8'h7f, 1'b0, 1'b0, 0);
        queue_beat(8'h01, 1'b0, 1'b1, $urandom_range(0, 10));
        counted = 15;

        // Random messages, lengths biased toward the padding boundaries
        while (counted < TARGET_BEATS)
        begin
            case ($urandom_range(0, 9))
                0:       msg_bytes = 0;
                1:       msg_bytes = $urandom_range(54, 57);
                2:       msg_bytes = $urandom_range(62, 65);
                3:       msg_bytes = $urandom_range(118, 128);
                default: msg_bytes = $urandom_range(1, 24);
            endcase
            fill_mode = $urandom_range(0, 5);
            calm_in   = ($urandom_range(0, 3) == 0);
            for (i = 0; i < msg_bytes; i++)
            begin
                case (fill_mode)
                    0:       b = 8'h00;
                    1:       b = 8'hff;
                    2:       b = PAD_BYTE;
                    default: b = byte_t'($urandom_range(0, 255));
                endcase
                // occasional idle beat with junk data inside the message
                if ($urandom_range(0, 19) == 0)
                begin
                    queue_beat(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0,
                               calm_in ? 0 : $urandom_range(0, 10));
                    counted++;
                end
                queue_beat(b, 1'b1, (i == msg_bytes - 1) && (msg_bytes % 2 == 1),
                           calm_in ? 0 : $urandom_range(0, 10));
                counted++;
            end
            // close with a separate beat when the last byte did not
            if (msg_bytes % 2 == 0)
            begin
                queue_beat(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1,
                           calm_in ? 0 : $urandom_range(0, 10));
                counted++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || in_valid || digest_words_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
